### src/chm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types, register indexes and reset values of the alarm monitor core.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int ADC_BITS_DEF = 10;
	localparam int TEMP_CH      = 4;
	localparam int CONTACT_CH   = 4;
	localparam int CAL_W        = 48;
	localparam int MAINS_THR_W  = 10;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = CAL_W;
	localparam int CH_IDX_W     = 2;
	localparam int CAUSE_W      = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL_0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAINS_LOW_ENTER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAINS_RECOVER  = 3'd5;

	localparam logic [CAL_W-1:0]       CAL_RESET          = 48'h0100_0000_7FFF;
	localparam logic [MAINS_THR_W-1:0] MAINS_ENTER_RESET  = 10'd124;
	localparam logic [MAINS_THR_W-1:0] MAINS_RECOVER_RESET = 10'd140;

	typedef enum logic [CAUSE_W-1:0] {
		CAUSE_NONE  = 3'd0,
		CAUSE_TEMP  = 3'd1,
		CAUSE_WATER = 3'd2,
		CAUSE_SMOKE = 3'd3,
		CAUSE_MAINS = 3'd4
	} cause_t;

	typedef struct packed {
		logic above_lim;
		logic below_release;
	} chm_cmp_t;

	typedef struct packed {
		logic                alert;
		cause_t              cause;
		logic [CH_IDX_W-1:0] chan;
		logic [TEMP_CH-1:0]  warn;
		logic                mains_low;
	} chm_result_t;

endpackage

### src/chm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_in_if
// Polling round channel: four temperature samples, contact bits, mains sample.
// ----------------------------------------------------------------------------
interface chm_in_if #(
	parameter int ADC_BITS = 10
);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] temp_adc_0;
	logic [ADC_BITS-1:0] temp_adc_1;
	logic [ADC_BITS-1:0] temp_adc_2;
	logic [ADC_BITS-1:0] temp_adc_3;
	logic [3:0]          water_bits;
	logic [3:0]          smoke_bits;
	logic [ADC_BITS-1:0] mains_adc;

	modport source (
		output valid, temp_adc_0, temp_adc_1, temp_adc_2, temp_adc_3,
		output water_bits, smoke_bits, mains_adc,
		input  ready
	);
	modport sink (
		input  valid, temp_adc_0, temp_adc_1, temp_adc_2, temp_adc_3,
		input  water_bits, smoke_bits, mains_adc,
		output ready
	);
endinterface

// ----------------------------------------------------------------------------
// chm_out_if
// Alarm result channel, one transaction per polling round.
// ----------------------------------------------------------------------------
interface chm_out_if;
	logic       valid;
	logic       ready;
	logic       alert;
	logic [2:0] cause;
	logic [1:0] cause_channel;
	logic [3:0] warn_flags;
	logic       mains_low;

	modport source (
		output valid, alert, cause, cause_channel, warn_flags, mains_low,
		input  ready
	);
	modport sink (
		input  valid, alert, cause, cause_channel, warn_flags, mains_low,
		output ready
	);
endinterface

### src/calibrated_hysteresis_alarm_monitor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calibrated_hysteresis_alarm_monitor_core
// Calibrated temperature, contact and mains alarm monitor with hysteresis.
// ----------------------------------------------------------------------------
// path: a round passes the input register, then the result register that drives result valid
// throughput: one round per cycle while out_ch.ready holds; the calibrate and
//   priority path between input register and result register is combinational
// reset: warning and mains flags clear, calibration returns to gain 1.0,
//   offset 0, limit 32767, mains thresholds 124 and 140
module calibrated_hysteresis_alarm_monitor_core #(
	parameter int ADC_BITS = chm_pkg::ADC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	chm_in_if.sink                          in_ch,
	chm_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [chm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [chm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import chm_pkg::*;

	logic [CAL_W-1:0]       cal_q [TEMP_CH];
	logic [MAINS_THR_W-1:0] enter_q;
	logic [MAINS_THR_W-1:0] recover_q;
	logic [TEMP_CH-1:0]     warn_q;
	logic                   mains_low_q;

	logic                   v_s1;
	logic [ADC_BITS-1:0]    adc_s1 [TEMP_CH];
	logic [CONTACT_CH-1:0]  water_s1;
	logic [CONTACT_CH-1:0]  smoke_s1;
	logic [ADC_BITS-1:0]    mains_s1;

	logic                   v_s2;
	chm_result_t            res_s2;

	chm_cmp_t [TEMP_CH-1:0] cmp;
	chm_result_t            res;
	logic                   load_s2;
	logic                   adv;
	logic                   in_fire;

	assign load_s2      = !v_s2 || out_ch.ready;
	assign adv          = v_s1 && load_s2;
	assign in_ch.ready  = !v_s1 || load_s2;
	assign in_fire      = in_ch.valid && in_ch.ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TEMP_CH; i++) cal_q[i] <= CAL_RESET;
			enter_q   <= MAINS_ENTER_RESET;
			recover_q <= MAINS_RECOVER_RESET;
		end else if (cfg_we) begin
			if (cfg_index < CFG_MAINS_LOW_ENTER) begin
				cal_q[cfg_index[CH_IDX_W-1:0] - CH_IDX_W'(CFG_TEMP_CAL_0)] <= cfg_data;
			end else if (cfg_index == CFG_MAINS_LOW_ENTER) begin
				enter_q <= cfg_data[MAINS_THR_W-1:0];
			end else if (cfg_index == CFG_MAINS_RECOVER) begin
				recover_q <= cfg_data[MAINS_THR_W-1:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (v_s1 && !adv) || in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			adc_s1[0] <= in_ch.temp_adc_0;
			adc_s1[1] <= in_ch.temp_adc_1;
			adc_s1[2] <= in_ch.temp_adc_2;
			adc_s1[3] <= in_ch.temp_adc_3;
			water_s1  <= in_ch.water_bits;
			smoke_s1  <= in_ch.smoke_bits;
			mains_s1  <= in_ch.mains_adc;
		end
	end

	for (genvar g = 0; g < TEMP_CH; g++) begin : g_chan
		chm_temp_cal #(
			.ADC_BITS(ADC_BITS)
		) u_cal (
			.adc(adc_s1[g]),
			.cal(cal_q[g]),
			.cmp(cmp[g])
		);
	end

	chm_alarm_eval #(
		.ADC_BITS(ADC_BITS)
	) u_eval (
		.cmp          (cmp),
		.warn_cur     (warn_q),
		.mains_low_cur(mains_low_q),
		.water        (water_s1),
		.smoke        (smoke_s1),
		.mains        (mains_s1),
		.thr_enter    (enter_q),
		.thr_recover  (recover_q),
		.res          (res)
	);

	// result register and flag state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			warn_q      <= '0;
			mains_low_q <= 1'b0;
		end else begin
			if (load_s2) v_s2 <= v_s1;
			if (adv) begin
				warn_q      <= res.warn;
				mains_low_q <= res.mains_low;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res;
	end

	assign out_ch.valid         = v_s2;
	assign out_ch.alert         = res_s2.alert;
	assign out_ch.cause         = res_s2.cause;
	assign out_ch.cause_channel = res_s2.chan;
	assign out_ch.warn_flags    = res_s2.warn;
	assign out_ch.mains_low     = res_s2.mains_low;

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(warn_q) && $stable(mains_low_q))
		else $error("flag state changed without a round");

	a_flags_follow: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (res_s2.warn == warn_q) && (res_s2.mains_low == mains_low_q))
		else $error("result flags differ from state");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> v_s1 && v_s2 && !out_ch.ready)
		else $error("input stalled without a full pipeline");

	a_mains_cause: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && (res_s2.cause == CAUSE_MAINS) |-> res_s2.mains_low && (res_s2.chan == '0))
		else $error("mains cause without low flag");

endmodule

### src/chm_temp_cal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_temp_cal
// Calibrates one temperature sample and compares it with the channel limit.
// ----------------------------------------------------------------------------
module chm_temp_cal #(
	parameter int ADC_BITS = chm_pkg::ADC_BITS_DEF
) (
	input  logic [ADC_BITS-1:0]     adc,
	input  logic [chm_pkg::CAL_W-1:0] cal,
	output chm_pkg::chm_cmp_t       cmp
);
	import chm_pkg::*;

	localparam int P_W   = ADC_BITS + 17;
	localparam int ACC_W = ADC_BITS + 18;
	localparam int T_W   = ACC_W - 8;
	localparam int M_W   = T_W + 4;

	logic signed [ADC_BITS:0]  a_s;
	logic signed [15:0]        gain;
	logic signed [15:0]        offs;
	logic signed [15:0]        lim;
	logic signed [P_W-1:0]     prod;
	logic signed [ACC_W-1:0]   acc;
	logic                      rnd;
	logic signed [T_W-1:0]     temp;
	logic signed [M_W-1:0]     temp_x10;
	logic signed [M_W-1:0]     lim_x9;

	assign a_s  = signed'({1'b0, adc});
	assign gain = signed'(cal[47:32]);
	assign offs = signed'(cal[31:16]);
	assign lim  = signed'(cal[15:0]);
	assign prod = a_s * gain;
	assign acc  = ACC_W'(prod) + ACC_W'(signed'({offs, 8'h00}));

	// divide by 256 truncating toward zero
	assign rnd  = acc[ACC_W-1] && (acc[7:0] != 8'h00);
	assign temp = signed'(acc[ACC_W-1:8] + T_W'(rnd));

	assign temp_x10 = (M_W'(temp) <<< 3) + (M_W'(temp) <<< 1);
	assign lim_x9   = (M_W'(lim) <<< 3) + M_W'(lim);

	assign cmp.above_lim     = temp > T_W'(lim);
	assign cmp.below_release = temp_x10 < lim_x9;
endmodule

### src/chm_alarm_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_alarm_eval
// Priority evaluation of one round: temperature, water, smoke, mains.
// ----------------------------------------------------------------------------
module chm_alarm_eval #(
	parameter int ADC_BITS = chm_pkg::ADC_BITS_DEF
) (
	input  chm_pkg::chm_cmp_t [chm_pkg::TEMP_CH-1:0] cmp,
	input  logic [chm_pkg::TEMP_CH-1:0]             warn_cur,
	input  logic                                    mains_low_cur,
	input  logic [chm_pkg::CONTACT_CH-1:0]          water,
	input  logic [chm_pkg::CONTACT_CH-1:0]          smoke,
	input  logic [ADC_BITS-1:0]                     mains,
	input  logic [chm_pkg::MAINS_THR_W-1:0]         thr_enter,
	input  logic [chm_pkg::MAINS_THR_W-1:0]         thr_recover,
	output chm_pkg::chm_result_t                    res
);
	import chm_pkg::*;

	localparam int MW = (ADC_BITS > MAINS_THR_W) ? ADC_BITS : MAINS_THR_W;

	logic [MW-1:0] mains_x;
	logic [MW-1:0] enter_x;
	logic [MW-1:0] recover_x;

	assign mains_x   = MW'(mains);
	assign enter_x   = MW'(thr_enter);
	assign recover_x = MW'(thr_recover);

	always_comb begin
		cause_t              cause;
		logic [CH_IDX_W-1:0] chan;
		logic [TEMP_CH-1:0]  warn;
		logic                ml;
		cause = CAUSE_NONE;
		chan  = '0;
		warn  = warn_cur;
		ml    = mains_low_cur;
		for (int i = 0; i < TEMP_CH; i++) begin
			if (cause == CAUSE_NONE) begin
				if (warn_cur[i]) begin
					if (cmp[i].below_release) warn[i] = 1'b0;
				end else if (cmp[i].above_lim) begin
					warn[i] = 1'b1;
					cause   = CAUSE_TEMP;
					chan    = CH_IDX_W'(i);
				end
			end
		end
		for (int i = 0; i < CONTACT_CH; i++) begin
			if (cause == CAUSE_NONE && water[i]) begin
				cause = CAUSE_WATER;
				chan  = CH_IDX_W'(i);
			end
		end
		for (int i = 0; i < CONTACT_CH; i++) begin
			if (cause == CAUSE_NONE && smoke[i]) begin
				cause = CAUSE_SMOKE;
				chan  = CH_IDX_W'(i);
			end
		end
		if (cause == CAUSE_NONE) begin
			if (mains_low_cur) begin
				if (mains_x > recover_x) ml = 1'b0;
				else cause = CAUSE_MAINS;
			end else if (mains_x <= enter_x) begin
				ml    = 1'b1;
				cause = CAUSE_MAINS;
			end
		end
		res.alert     = cause != CAUSE_NONE;
		res.cause     = cause;
		res.chan      = chan;
		res.warn      = warn;
		res.mains_low = ml;
	end
endmodule
